// ===== hdl/bfgl_pkg.sv =====
// Shared types, register codes and constants for the bitmap font glyph layout core.
// No dependencies; every other file of the block but bfgl_div imports this package.
`default_nettype none

package bfgl_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_ATLAS_ROWS   = 3'd2,
    REG_ATLAS_COLS   = 3'd3,
    REG_BASE_CHAR    = 3'd4,
    REG_DRAW_SCALE   = 3'd5,
    REG_ADVANCE_TRIM = 3'd6,
    REG_TINT_COLOR   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  atlas_rows;
    logic [7:0]  atlas_cols;
    logic [7:0]  base_char;
    logic [11:0] draw_scale;
    logic [7:0]  advance_trim;
    logic [31:0] tint_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               new_string;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [15:0]        cell_left;
    logic [15:0]        cell_top;
    logic [15:0]        cell_right;
    logic [15:0]        cell_bottom;
    logic [31:0]        draw_color;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CLASS,
    S_STEP,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic nl;
    logic adv;
    logic div_start;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_nl;
    logic glyph_ok;
    logic div_done;
    logic slot_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bfgl_div.sv =====
// Restoring divider, one quotient bit per cycle, 8-bit operands.
// Depends on nothing but the clock and reset; used by bfgl_dp.
`default_nettype none

module bfgl_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      quotient,
  output logic [7:0]      remainder
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [8:0] shifted;
  logic [8:0] trial;

  always_comb begin
    shifted  = {rem_r, quo_r[7]};
    trial    = shifted - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // keep the trial difference when it did not go negative
      rem_nxt  = trial[8] ? shifted[7:0] : trial[7:0];
      quo_nxt  = {quo_r[6:0], ~trial[8]};
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hdl/bfgl_dp.sv =====
// Layout datapath: pen state, advance and line step, atlas cell math, output register.
// Depends on bfgl_pkg and instantiates bfgl_div.
`default_nettype none

module bfgl_dp
  import bfgl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire in_item_t  in_data,
  input  wire dp_cmd_t   cmd,
  output dp_sts_t        sts,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_data
);

  in_item_t               item_r;
  logic [7:0]             ch_r, ch_nxt;
  logic [COORD_BITS-1:0]  pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0]  pen_y_r, pen_y_nxt;
  logic [COORD_BITS-1:0]  line_x_r, line_x_nxt;
  logic signed [21:0]     prod_r;
  logic signed [21:0]     biased;
  logic signed [13:0]     adv_r;
  logic [19:0]            hprod;
  logic [11:0]            lstep_r;
  logic [15:0]            cnt_r;
  logic signed [8:0]      diff;
  logic [8:0]             idx;
  logic [31:0]            adv_ext;
  logic [31:0]            lstep_ext;
  logic [31:0]            org_x_ext;
  logic [31:0]            org_y_ext;
  logic [31:0]            px_ext;
  logic [31:0]            py_ext;
  logic                   div_done;
  logic [7:0]             quo;
  logic [7:0]             rem;
  logic [15:0]            left_r;
  logic [15:0]            top_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r;

  // Config-derived terms, refreshed every cycle
  assign diff   = $signed({1'b0, cfg.glyph_width}) - $signed({1'b0, cfg.advance_trim});
  assign hprod  = 20'(cfg.glyph_height) * 20'(cfg.draw_scale);
  assign biased = prod_r + (prod_r[21] ? 22'sd255 : 22'sd0);

  always_ff @(posedge clk) begin
    prod_r  <= 22'(diff) * 22'($signed({1'b0, cfg.draw_scale}));
    adv_r   <= biased[21:8];
    lstep_r <= hprod[19:8];
    cnt_r   <= 16'(cfg.atlas_rows) * 16'(cfg.atlas_cols);
  end

  assign adv_ext   = 32'(adv_r);
  assign lstep_ext = 32'(lstep_r);
  assign org_x_ext = 32'(item_r.origin_x);
  assign org_y_ext = 32'(item_r.origin_y);
  assign px_ext    = 32'(pen_x_r);
  assign py_ext    = 32'(pen_y_r);

  // Fold lowercase, classify the folded character
  always_comb begin
    ch_nxt = item_r.char_code;
    if (item_r.char_code >= CHAR_LOWER_A && item_r.char_code <= CHAR_LOWER_Z) begin
      ch_nxt = item_r.char_code - CASE_OFFSET;
    end
  end

  assign idx           = {1'b0, ch_r} - {1'b0, cfg.base_char};
  assign sts.is_space  = (ch_r == CHAR_SPACE);
  assign sts.is_nl     = (ch_r == CHAR_NEWLINE);
  assign sts.glyph_ok  = !idx[8] && (cfg.atlas_cols != 8'd0) && ({8'd0, idx[7:0]} < cnt_r);
  assign sts.div_done  = div_done;
  assign sts.slot_free = !out_valid_r || out_ready;

  bfgl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (idx[7:0]),
    .divisor   (cfg.atlas_cols),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    pen_x_nxt  = pen_x_r;
    pen_y_nxt  = pen_y_r;
    line_x_nxt = line_x_r;
    if (cmd.prep && item_r.new_string) begin
      pen_x_nxt  = org_x_ext[COORD_BITS-1:0];
      pen_y_nxt  = org_y_ext[COORD_BITS-1:0];
      line_x_nxt = org_x_ext[COORD_BITS-1:0];
    end else if (cmd.nl) begin
      pen_y_nxt = pen_y_r + lstep_ext[COORD_BITS-1:0];
      pen_x_nxt = line_x_r;
    end else if (cmd.adv || cmd.out_load) begin
      pen_x_nxt = pen_x_r + adv_ext[COORD_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      line_x_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      line_x_r    <= line_x_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.prep) begin
      ch_r <= ch_nxt;
    end
    if (cmd.mul) begin
      left_r <= 16'(rem) * 16'(cfg.glyph_width);
      top_r  <= 16'(quo) * 16'(cfg.glyph_height);
    end
    if (cmd.out_load) begin
      out_r.screen_x    <= px_ext[15:0];
      out_r.screen_y    <= py_ext[15:0];
      out_r.cell_left   <= left_r;
      out_r.cell_top    <= top_r;
      out_r.cell_right  <= left_r + {8'd0, cfg.glyph_width};
      out_r.cell_bottom <= top_r + {8'd0, cfg.glyph_height};
      out_r.draw_color  <= cfg.tint_color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_pen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.prep || cmd.nl || cmd.adv || cmd.out_load) |=> $stable(pen_x_r))
    else $error("pen x moved without a command");

  a_pen_y_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.adv || cmd.out_load) |=> $stable(pen_y_r))
    else $error("pen y moved on a horizontal advance");

endmodule

`default_nettype wire

// ===== hdl/bfgl_ctrl.sv =====
// Sequencer for one character: decode, step, divide, multiply, emit.
// Depends on bfgl_pkg; drives bfgl_dp through dp_cmd_t and reads dp_sts_t.
`default_nettype none

module bfgl_ctrl
  import bfgl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_CLASS;
      S_CLASS: begin
        if (sts.is_space) begin
          state_nxt = S_STEP;
        end else if (sts.is_nl) begin
          state_nxt = S_IDLE;
        end else if (sts.glyph_ok) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STEP: state_nxt = S_IDLE;
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_OUT;
      S_OUT: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PREP:  cmd.prep = 1'b1;
      S_CLASS: begin
        cmd.nl        = sts.is_nl && !sts.is_space;
        cmd.div_start = sts.glyph_ok && !sts.is_space && !sts.is_nl;
      end
      S_STEP:  cmd.adv = 1'b1;
      S_DIV:   cmd = '0;
      S_MUL:   cmd.mul = 1'b1;
      S_OUT:   cmd.out_load = sts.slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted transaction did not enter decode");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_div_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_done) |=> cmd.mul)
    else $error("cell multiply did not follow the divide");

endmodule

`default_nettype wire

// ===== hdl/bitmap_font_glyph_layout_core.sv =====
// Sequence: a character is taken in idle, latched, then decoded and classified; a glyph
// goes on through the divide, multiply and output states, a space through one pen step,
// and a newline or a skipped character returns to idle. One character at a time; the
// 8-iteration divider splits the glyph index into atlas column and row.
// The result register lets the next character enter while a result waits.
// Reset (synchronous, rst_n low): pen, line start, state and result valid clear;
// configuration returns to its defaults. Depends on bfgl_pkg, bfgl_ctrl, bfgl_dp.
`default_nettype none

module bitmap_font_glyph_layout_core
  import bfgl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_wdata[7:0];
        REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_wdata[7:0];
        REG_ATLAS_ROWS:   cfg_nxt.atlas_rows   = cfg_wdata[7:0];
        REG_ATLAS_COLS:   cfg_nxt.atlas_cols   = cfg_wdata[7:0];
        REG_BASE_CHAR:    cfg_nxt.base_char    = cfg_wdata[7:0];
        REG_DRAW_SCALE:   cfg_nxt.draw_scale   = cfg_wdata[11:0];
        REG_ADVANCE_TRIM: cfg_nxt.advance_trim = cfg_wdata[7:0];
        REG_TINT_COLOR:   cfg_nxt.tint_color   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width  <= 8'd1;
      cfg_r.glyph_height <= 8'd1;
      cfg_r.atlas_rows   <= 8'd1;
      cfg_r.atlas_cols   <= 8'd1;
      cfg_r.base_char    <= CHAR_SPACE;
      cfg_r.draw_scale   <= 12'd256;
      cfg_r.advance_trim <= 8'd0;
      cfg_r.tint_color   <= 32'hFFFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfgl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfgl_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for bitmap_font_glyph_layout_core: drives characters and
// register writes, predicts every draw command, and checks each one as it leaves.
// Depends on bfgl_pkg and the core RTL only.
`default_nettype none

module testbench;
  import bfgl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the draw commands of the core and checks them in order.
  class draw_scoreboard;
    cfg_t        regs;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [15:0] line_x;
    out_item_t   expected_draws[$];
    int          mismatches;

    function new();
      regs = '{glyph_width: 8'd1, glyph_height: 8'd1, atlas_rows: 8'd1, atlas_cols: 8'd1,
               base_char: 8'd32, draw_scale: 12'd256, advance_trim: 8'd0,
               tint_color: 32'hFFFF_FFFF};
      pen_x = '0;
      pen_y = '0;
      line_x = '0;
      mismatches = 0;
    endfunction

    // Signed (width - trim) * scale in Q4.8, truncated toward zero.
    function logic [15:0] pen_step();
      int diff;
      int adv;
      diff = int'(regs.glyph_width) - int'(regs.advance_trim);
      adv = (diff * int'(regs.draw_scale)) / 256;
      return adv[15:0];
    endfunction

    function void lay_out_char(in_item_t it);
      logic [7:0]  ch;
      int          idx;
      int          count;
      int          col;
      int          row;
      logic [31:0] left;
      logic [31:0] top;
      out_item_t   draw;
      if (it.new_string) begin
        pen_x = it.origin_x;
        pen_y = it.origin_y;
        line_x = it.origin_x;
      end
      ch = it.char_code;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
        ch = ch - CASE_OFFSET;
      end
      if (ch == CHAR_SPACE) begin
        pen_x = pen_x + pen_step();
        return;
      end
      if (ch == CHAR_NEWLINE) begin
        pen_y = pen_y + 16'((32'(regs.glyph_height) * 32'(regs.draw_scale)) >> 8);
        pen_x = line_x;
        return;
      end
      idx = int'(ch) - int'(regs.base_char);
      count = int'(regs.atlas_rows) * int'(regs.atlas_cols);
      // drop characters outside the atlas; the pen stays put
      if (idx < 0 || regs.atlas_cols == 8'd0 || idx >= count) begin
        return;
      end
      col = idx % int'(regs.atlas_cols);
      row = idx / int'(regs.atlas_cols);
      left = 32'(col) * 32'(regs.glyph_width);
      top = 32'(row) * 32'(regs.glyph_height);
      draw.screen_x = pen_x;
      draw.screen_y = pen_y;
      draw.cell_left = left[15:0];
      draw.cell_top = top[15:0];
      draw.cell_right = 16'(left + 32'(regs.glyph_width));
      draw.cell_bottom = 16'(top + 32'(regs.glyph_height));
      draw.draw_color = regs.tint_color;
      expected_draws.push_back(draw);
      pen_x = pen_x + pen_step();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 200) begin
        $display("%0t draw mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
    endtask

    task check_draw(out_item_t got);
      out_item_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got.screen_x), '0);
        return;
      end
      want = expected_draws.pop_front();
      if (got.screen_x !== want.screen_x)
        report_mismatch("screen_x", 32'(got.screen_x), 32'(want.screen_x));
      if (got.screen_y !== want.screen_y)
        report_mismatch("screen_y", 32'(got.screen_y), 32'(want.screen_y));
      if (got.cell_left !== want.cell_left)
        report_mismatch("cell_left", 32'(got.cell_left), 32'(want.cell_left));
      if (got.cell_top !== want.cell_top)
        report_mismatch("cell_top", 32'(got.cell_top), 32'(want.cell_top));
      if (got.cell_right !== want.cell_right)
        report_mismatch("cell_right", 32'(got.cell_right), 32'(want.cell_right));
      if (got.cell_bottom !== want.cell_bottom)
        report_mismatch("cell_bottom", 32'(got.cell_bottom), 32'(want.cell_bottom));
      if (got.draw_color !== want.draw_color)
        report_mismatch("draw_color", got.draw_color, want.draw_color);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  draw_scoreboard layout = new();
  bit sender_calm = 1'b0;
  bit reader_calm = 1'b0;

  bitmap_font_glyph_layout_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Hold valid and payload until the transaction is taken.
  task automatic send_char(input in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    layout.lay_out_char(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (layout.expected_draws.size() != 0) @(posedge clk);
    // spaces, newlines and skipped characters may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    cfg_reg_t    r;
    logic [31:0] v;
    drain();
    r = r.first();
    do begin
      case (r)
        REG_GLYPH_WIDTH:  v = 32'(c.glyph_width);
        REG_GLYPH_HEIGHT: v = 32'(c.glyph_height);
        REG_ATLAS_ROWS:   v = 32'(c.atlas_rows);
        REG_ATLAS_COLS:   v = 32'(c.atlas_cols);
        REG_BASE_CHAR:    v = 32'(c.base_char);
        REG_DRAW_SCALE:   v = 32'(c.draw_scale);
        REG_ADVANCE_TRIM: v = 32'(c.advance_trim);
        default:          v = c.tint_color;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v;
      @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_we <= 1'b0;
    layout.regs = c;
  endtask

  function automatic in_item_t make_char(logic [7:0] code, bit start,
                                         logic [15:0] x, logic [15:0] y);
    in_item_t it;
    it.char_code = code;
    it.new_string = start;
    it.origin_x = start ? x : 16'($urandom);
    it.origin_y = start ? y : 16'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] pick_setting(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Mostly glyphs inside the atlas, with spaces, newlines and stray bytes mixed in.
  function automatic in_item_t random_char();
    in_item_t it;
    int       count;
    int       span;
    int       pick;
    it.new_string = ($urandom_range(0, 11) == 0);
    it.origin_x = 16'($urandom);
    it.origin_y = 16'($urandom);
    count = int'(layout.regs.atlas_rows) * int'(layout.regs.atlas_cols);
    span = 255 - int'(layout.regs.base_char);
    if (count - 1 < span) span = count - 1;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.char_code = CHAR_SPACE;
    end else if (pick < 14) begin
      it.char_code = CHAR_NEWLINE;
    end else if (pick < 26 || count == 0) begin
      it.char_code = 8'($urandom);
    end else begin
      it.char_code = layout.regs.base_char + 8'($urandom_range(0, span));
      if (it.char_code >= CHAR_LOWER_A - CASE_OFFSET && it.char_code <= CHAR_LOWER_Z - CASE_OFFSET
          && $urandom_range(0, 1) == 1) begin
        it.char_code = it.char_code + CASE_OFFSET;
      end
    end
    return it;
  endfunction

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) reader_calm = !reader_calm;
      gap = reader_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      layout.check_draw(out_data);
    end
  end

  initial begin
    cfg_t c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GLYPH_WIDTH;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // default atlas holds only the space glyph
    send_char(make_char("!", 1'b1, 16'h8000, 16'h7FFF));
    send_char(make_char(CHAR_SPACE, 1'b0, '0, '0));

    c = '{glyph_width: 8'd8, glyph_height: 8'd12, atlas_rows: 8'd6, atlas_cols: 8'd16,
          base_char: 8'd32, draw_scale: 12'd256, advance_trim: 8'd1,
          tint_color: 32'h1234_5678};
    program_regs(c);
    send_char(make_char("A", 1'b1, 16'h7FFF, 16'h8000));
    send_char(make_char("a", 1'b0, '0, '0));
    send_char(make_char("z", 1'b0, '0, '0));
    send_char(make_char(CHAR_SPACE, 1'b0, '0, '0));
    send_char(make_char(CHAR_NEWLINE, 1'b0, '0, '0));
    send_char(make_char("!", 1'b0, '0, '0));
    send_char(make_char(8'h7F, 1'b0, '0, '0));
    send_char(make_char(8'h80, 1'b0, '0, '0));
    send_char(make_char(8'h1F, 1'b0, '0, '0));
    send_char(make_char(8'hFF, 1'b0, '0, '0));

    // trim above width moves the pen left; full 256-glyph atlas from code zero
    c = '{glyph_width: 8'd8, glyph_height: 8'd255, atlas_rows: 8'd16, atlas_cols: 8'd16,
          base_char: 8'd0, draw_scale: 12'd4095, advance_trim: 8'd255,
          tint_color: 32'h0000_0000};
    program_regs(c);
    send_char(make_char(8'h00, 1'b1, 16'h0000, 16'h0000));
    send_char(make_char(8'hFF, 1'b0, '0, '0));
    send_char(make_char("q", 1'b0, '0, '0));
    send_char(make_char(CHAR_SPACE, 1'b0, '0, '0));
    send_char(make_char(CHAR_NEWLINE, 1'b0, '0, '0));
    send_char(make_char(8'h80, 1'b0, '0, '0));

    // empty atlas: zero rows, then zero columns
    c.atlas_rows = 8'd0;
    program_regs(c);
    send_char(make_char("B", 1'b0, '0, '0));
    c.atlas_rows = 8'd5;
    c.atlas_cols = 8'd0;
    program_regs(c);
    send_char(make_char("B", 1'b0, '0, '0));
    send_char(make_char(CHAR_NEWLINE, 1'b0, '0, '0));

    for (int p = 0; p < 10; p++) begin
      c.glyph_width = 8'(pick_setting(1, 255));
      c.glyph_height = 8'(pick_setting(1, 255));
      c.atlas_rows = 8'(pick_setting(1, 255));
      c.atlas_cols = 8'(pick_setting(1, 255));
      c.base_char = 8'(pick_setting(0, 127));
      c.draw_scale = 12'(pick_setting(0, 4095));
      c.advance_trim = 8'(pick_setting(0, 255));
      c.tint_color = pick_setting(0, 32'hFFFF_FFFF);
      program_regs(c);
      repeat (160) send_char(random_char());
    end

    drain();
    if (layout.mismatches == 0 && layout.expected_draws.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== bitmap_font_glyph_layout_core.f =====
hdl/bfgl_pkg.sv
hdl/bfgl_div.sv
hdl/bfgl_dp.sv
hdl/bfgl_ctrl.sv
hdl/bitmap_font_glyph_layout_core.sv
test/testbench.sv
